@@ hw/rtl/cht_pkg.sv @@
`timescale 1ns / 1ps

package cht_pkg;

    localparam int NUM_WAYS_DEF  = 9;
    localparam int WAY_DEPTH_DEF = 1024;
    localparam int MAX_KICKS_DEF = 12;
    localparam int KEY_BITS      = 64;
    localparam int VALUE_BITS    = 16;
    localparam int ROM_BITS      = 16;
    localparam logic [31:0] ROM_SEED = 32'h9E37_79B9;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;

    typedef struct packed {
        logic [1:0]            func;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  source;
    } req_t;

    typedef struct packed {
        logic [1:0]            func_echo;
        logic [KEY_BITS-1:0]   key_echo;
        logic [VALUE_BITS-1:0] result_value;
        logic                  found_or_done;
        logic                  source_echo;
        logic [15:0]           failure_count;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_EVRD,
        ST_EVWB,
        ST_FINISH
    } state_t;

    // Word n of the hash table: the xorshift generator stepped n+1 times from the seed.
    function automatic logic [ROM_BITS-1:0] rom_word(input int unsigned n);
        logic [31:0] x;
        x = ROM_SEED;
        for (int unsigned i = 0; i <= n; i++) begin
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
        end
        return x[ROM_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/cht_ram.sv @@
`timescale 1ns / 1ps

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cuckoo_hash_table_unit.sv @@
`timescale 1ns / 1ps
// Lookup and delete scan every way, one table read per way through the single RAM read port,
// then pass a decide state and a finish state that waits for the output register to be free.
// An insert that finds a free way writes it in the decide state; otherwise each eviction trial
// finishes the victim remainder, reads the victim, swaps it and then rescans and decides again
// (the last trial of a failed insert skips the rescan). One item at a time.
// After reset all NUM_WAYS*WAY_DEPTH table entries are cleared first, one entry per cycle.
module cuckoo_hash_table_unit #(
    parameter int NUM_WAYS  = cht_pkg::NUM_WAYS_DEF,
    parameter int WAY_DEPTH = cht_pkg::WAY_DEPTH_DEF,
    parameter int MAX_KICKS = cht_pkg::MAX_KICKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cht_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output cht_pkg::rsp_t out_data
);

    localparam int WBITS     = $clog2(NUM_WAYS);
    localparam int CBITS     = $clog2(NUM_WAYS + 1);
    localparam int ABITS     = $clog2(WAY_DEPTH);
    localparam int AW        = WBITS + ABITS;
    localparam int RAM_DEPTH = NUM_WAYS * WAY_DEPTH;
    localparam int DIVISOR   = NUM_WAYS - 1;
    localparam int RSH       = ABITS + 4;
    localparam int RECIP     = ((1 << RSH) + DIVISOR - 1) / DIVISOR;
    localparam int PW        = ABITS + RSH + 1;
    localparam int TBITS     = $clog2(MAX_KICKS + 1);
    localparam int KB        = cht_pkg::KEY_BITS;
    localparam int VB        = cht_pkg::VALUE_BITS;

    logic [cht_pkg::ROM_BITS-1:0] rom_tab [NUM_WAYS][2][KB];

    for (genvar gw = 0; gw < NUM_WAYS; gw++)
    begin : g_way
        for (genvar gb = 0; gb < 2; gb++)
        begin : g_bit
            for (genvar gk = 0; gk < KB; gk++)
            begin : g_pos
                localparam logic [cht_pkg::ROM_BITS-1:0] WORD =
                    cht_pkg::rom_word((gw * 2 + gb) * KB + gk);
                assign rom_tab[gw][gb][gk] = WORD;
            end
        end
    end

    cht_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [CBITS-1:0] w_reg, w_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [WBITS-1:0] chk_way_reg, chk_way_next;
    logic [ABITS-1:0] chk_idx_reg, chk_idx_next;
    logic [1:0]       func_reg, func_next;
    logic [KB-1:0]    key_reg, key_next;
    logic [VB-1:0]    val_reg, val_next;
    logic             src_reg, src_next;
    logic [15:0]      before_reg, before_next;
    logic [KB-1:0]    cur_key_reg, cur_key_next;
    logic [VB-1:0]    cur_val_reg, cur_val_next;
    logic             hit_reg, hit_next;
    logic [VB-1:0]    rv_reg, rv_next;
    logic             free_reg, free_next;
    logic [WBITS-1:0] free_way_reg, free_way_next;
    logic [ABITS-1:0] free_idx_reg, free_idx_next;
    logic [ABITS-1:0] hv_reg, hv_next;
    logic [ABITS-1:0] quo_reg, quo_next;
    logic [WBITS-1:0] pos_reg, pos_next;
    logic [ABITS-1:0] ev_idx_reg, ev_idx_next;
    logic [WBITS-1:0] vidx_reg, vidx_next;
    logic [TBITS-1:0] trial_reg, trial_next;
    logic             toggle_reg, toggle_next;
    logic [15:0]      fail_reg, fail_next;
    logic             out_valid_reg, out_valid_next;
    cht_pkg::rsp_t    out_reg, out_next;

    logic [WBITS-1:0]             hash_way;
    logic [cht_pkg::ROM_BITS-1:0] hash_acc;
    logic [ABITS-1:0]             hash_idx;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    cht_pkg::entry_t              ram_wdata;
    cht_pkg::entry_t              ram_rdata;
    logic [PW-1:0]                recip_prod;
    logic [ABITS-1:0]             quo;
    logic [ABITS-1:0]             rem_val;
    logic                         match;

    assign hash_way = (state_reg == cht_pkg::ST_EVRD) ? pos_reg : w_reg[WBITS-1:0];

    always_comb
    begin
        hash_acc = '0;
        for (int k = 0; k < KB; k++)
        begin
            hash_acc = hash_acc ^ rom_tab[hash_way][cur_key_reg[k]][k];
        end
    end

    assign hash_idx = hash_acc[ABITS-1:0];

    cht_ram #(
        .WIDTH ($bits(cht_pkg::entry_t)),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({hash_way, hash_idx}),
        .rdata (ram_rdata)
    );

    // Remainder by NUM_WAYS-1 through a reciprocal multiply, which is exact for ABITS-bit
    // hashes; the quotient is registered and the remainder formed in the next cycle.
    assign recip_prod = PW'(hv_reg) * PW'(RECIP);
    assign quo        = recip_prod[RSH +: ABITS];
    assign rem_val    = hv_reg - (quo_reg * ABITS'(DIVISOR));
    assign match      = ram_rdata.valid && (ram_rdata.key == cur_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cht_pkg::ST_CLEAR;
            clr_reg       <= '0;
            chk_valid_reg <= 1'b0;
            toggle_reg    <= 1'b0;
            fail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_valid_reg <= chk_valid_next;
            toggle_reg    <= toggle_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        chk_way_reg  <= chk_way_next;
        chk_idx_reg  <= chk_idx_next;
        func_reg     <= func_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        src_reg      <= src_next;
        before_reg   <= before_next;
        cur_key_reg  <= cur_key_next;
        cur_val_reg  <= cur_val_next;
        hit_reg      <= hit_next;
        rv_reg       <= rv_next;
        free_reg     <= free_next;
        free_way_reg <= free_way_next;
        free_idx_reg <= free_idx_next;
        hv_reg       <= hv_next;
        quo_reg      <= quo_next;
        pos_reg      <= pos_next;
        ev_idx_reg   <= ev_idx_next;
        vidx_reg     <= vidx_next;
        trial_reg    <= trial_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        w_next         = w_reg;
        chk_valid_next = 1'b0;
        chk_way_next   = chk_way_reg;
        chk_idx_next   = chk_idx_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        src_next       = src_reg;
        before_next    = before_reg;
        cur_key_next   = cur_key_reg;
        cur_val_next   = cur_val_reg;
        hit_next       = hit_reg;
        rv_next        = rv_reg;
        free_next      = free_reg;
        free_way_next  = free_way_reg;
        free_idx_next  = free_idx_reg;
        hv_next        = hv_reg;
        quo_next       = quo_reg;
        pos_next       = pos_reg;
        ev_idx_next    = ev_idx_reg;
        vidx_next      = vidx_reg;
        trial_next     = trial_reg;
        toggle_next    = toggle_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {chk_way_reg, chk_idx_reg};
        ram_wdata      = '0;

        unique case (state_reg)
            cht_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(RAM_DEPTH - 1))
                begin
                    state_next = cht_pkg::ST_IDLE;
                end
            end
            cht_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next    = in_data.func;
                    key_next     = in_data.key;
                    val_next     = in_data.value;
                    src_next     = in_data.source;
                    before_next  = fail_reg;
                    cur_key_next = in_data.key;
                    cur_val_next = in_data.value;
                    hit_next     = 1'b0;
                    rv_next      = '0;
                    free_next    = 1'b0;
                    w_next       = '0;
                    vidx_next    = '0;
                    trial_next   = '0;
                    state_next   = cht_pkg::ST_SCAN;
                end
            end
            cht_pkg::ST_SCAN:
            begin
                // Issue the read for way w while checking the data of the way before it.
                if (w_reg < CBITS'(NUM_WAYS))
                begin
                    chk_valid_next = 1'b1;
                    chk_way_next   = w_reg[WBITS-1:0];
                    chk_idx_next   = hash_idx;
                    if (w_reg == CBITS'(vidx_reg))
                    begin
                        hv_next = hash_idx;
                    end
                    w_next = w_reg + 1'b1;
                end
                else
                begin
                    state_next = cht_pkg::ST_DECIDE;
                end
                if (chk_valid_reg)
                begin
                    if (func_reg == cht_pkg::FUNC_LOOKUP)
                    begin
                        if (match)
                        begin
                            hit_next = 1'b1;
                            rv_next  = ram_rdata.value;
                        end
                    end
                    else if (func_reg == cht_pkg::FUNC_INSERT)
                    begin
                        if (!ram_rdata.valid)
                        begin
                            free_next     = 1'b1;
                            free_way_next = chk_way_reg;
                            free_idx_next = chk_idx_reg;
                        end
                    end
                    else if (match)
                    begin
                        ram_we   = 1'b1;
                        hit_next = 1'b1;
                    end
                end
            end
            cht_pkg::ST_DECIDE:
            begin
                if (func_reg == cht_pkg::FUNC_INSERT)
                begin
                    if (free_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = {free_way_reg, free_idx_reg};
                        ram_wdata   = '{valid: 1'b1, key: cur_key_reg, value: cur_val_reg};
                        toggle_next = !toggle_reg;
                        hit_next    = 1'b1;
                        state_next  = cht_pkg::ST_FINISH;
                    end
                    else
                    begin
                        quo_next   = quo;
                        state_next = cht_pkg::ST_MOD;
                    end
                end
                else
                begin
                    state_next = cht_pkg::ST_FINISH;
                end
            end
            cht_pkg::ST_MOD:
            begin
                pos_next   = rem_val[WBITS-1:0] + WBITS'(toggle_reg);
                state_next = cht_pkg::ST_EVRD;
            end
            cht_pkg::ST_EVRD:
            begin
                ev_idx_next = hash_idx;
                state_next  = cht_pkg::ST_EVWB;
            end
            cht_pkg::ST_EVWB:
            begin
                ram_we       = 1'b1;
                ram_waddr    = {pos_reg, ev_idx_reg};
                ram_wdata    = '{valid: 1'b1, key: cur_key_reg, value: cur_val_reg};
                cur_key_next = ram_rdata.key;
                cur_val_next = ram_rdata.value;
                toggle_next  = !toggle_reg;
                vidx_next    = (vidx_reg == WBITS'(NUM_WAYS - 1)) ? '0 : vidx_reg + 1'b1;
                if (trial_reg == TBITS'(MAX_KICKS - 1))
                begin
                    fail_next  = fail_reg + 16'd1;
                    hit_next   = 1'b0;
                    state_next = cht_pkg::ST_FINISH;
                end
                else
                begin
                    trial_next = trial_reg + 1'b1;
                    w_next     = '0;
                    free_next  = 1'b0;
                    state_next = cht_pkg::ST_SCAN;
                end
            end
            cht_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.func_echo     = func_reg;
                    out_next.key_echo      = key_reg;
                    out_next.result_value  =
                        (func_reg == cht_pkg::FUNC_LOOKUP) ? rv_reg : val_reg;
                    out_next.found_or_done = hit_reg;
                    out_next.source_echo   = src_reg;
                    out_next.failure_count = before_reg;
                    out_valid_next         = 1'b1;
                    state_next             = cht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cht_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new transaction accepted while one is in progress");

    a_scan_write_delete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cht_pkg::ST_SCAN && ram_we) |->
            (func_reg != cht_pkg::FUNC_LOOKUP && func_reg != cht_pkg::FUNC_INSERT))
        else $error("table written during scan by a non-delete");

    a_victim_way: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cht_pkg::ST_EVRD) |-> (int'(pos_reg) < NUM_WAYS))
        else $error("eviction way out of range");

endmodule
